/* rtl/core/kqt_pkg.sv */
// Shared types and codes for the keyed ordered queue table.
package kqt_pkg;

  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_REMOVE_KEY = 3'd1,
    OP_REMOVE_POS = 3'd2,
    OP_QUERY      = 3'd3,
    OP_RENAME     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_MATCH = 2'd1,
    ST_APPLY = 2'd2
  } state_e;

  typedef struct packed {
    logic shift;
    logic load;
    logic rename;
  } cell_ctrl_t;

  typedef struct packed {
    logic in_stall;
    logic capture;
    logic match_en;
    logic apply;
  } seq_ctrl_t;

endpackage

/* rtl/core/kqt_cell.sv */
// One table slot: holds an entry, compares it, and takes its neighbor's entry on a shift.
module kqt_cell #(
  parameter int KEY_W = 64
) (
  input  logic               clk_i,
  input  kqt_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]         nb_grp_i,
  input  logic [KEY_W-1:0]   nb_key_i,
  input  logic [31:0]        nb_amt_i,
  input  logic [7:0]         wr_grp_i,
  input  logic [KEY_W-1:0]   wr_key_i,
  input  logic [31:0]        wr_amt_i,
  input  logic [7:0]         cmp_grp_i,
  input  logic [KEY_W-1:0]   cmp_key_i,
  output logic [7:0]         grp_o,
  output logic [KEY_W-1:0]   key_o,
  output logic [31:0]        amt_o,
  output logic               match_o
);

  logic [7:0]       grp_q, grp_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [31:0]      amt_q, amt_d;

  always_comb begin
    grp_d = grp_q;
    key_d = key_q;
    amt_d = amt_q;
    if (ctrl_i.shift) begin
      grp_d = nb_grp_i;
      key_d = nb_key_i;
      amt_d = nb_amt_i;
    end else if (ctrl_i.load) begin
      grp_d = wr_grp_i;
      key_d = wr_key_i;
      amt_d = wr_amt_i;
    end else if (ctrl_i.rename) begin
      grp_d = wr_grp_i;
      key_d = wr_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    key_q <= key_d;
    amt_q <= amt_d;
  end

  assign match_o = (grp_q == cmp_grp_i) && (key_q == cmp_key_i);
  assign grp_o   = grp_q;
  assign key_o   = key_q;
  assign amt_o   = amt_q;

endmodule

/* rtl/core/kqt_first.sv */
// Parallel-prefix OR that marks every slot at or after the first match.
module kqt_first #(
  parameter int DEPTH = 64
) (
  input  logic [DEPTH-1:0] match_i,
  output logic [DEPTH-1:0] incl_o
);

  localparam int LV = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DEPTH-1:0] pre [LV+1];

  assign pre[0] = match_i;

  for (genvar l = 0; l < LV; l++) begin : g_lvl
    assign pre[l+1] = pre[l] | (pre[l] << (1 << l));
  end

  assign incl_o = pre[LV];

endmodule

/* rtl/core/keyed_ordered_queue_table.sv */
// Top level of the keyed ordered queue table: a chain of entry cells and its sequencer.
//
// The input channel carries one operation per beat (append, remove by key,
// remove at position, query, rename); the output channel returns one result
// beat per operation with found, dropped and the entry count afterwards.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low.
// An operation runs in three steps: the beat is registered, every cell then
// compares its entry with the group and key in parallel and the match
// vector is registered, and in the apply step a prefix OR picks the first
// match while the cells shift toward the head, load or rename in one step.
// The input stalls in the compare and apply steps, so a new beat is taken
// only once the last has finished. The result sits in an output register;
// while the receiver stalls, a new beat is still taken and compared, and
// its apply step waits until the output register is free.
// Reset empties the table (count zero) and clears the output valid; the
// entry contents are not reset.
module keyed_ordered_queue_table #(
  parameter int DEPTH     = 64,
  parameter int KEY_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [7:0]  entry_block_i,
  input  logic [63:0] flat_id_i,
  input  logic [31:0] amount_cents_i,
  input  logic [5:0]  position_i,
  input  logic [7:0]  new_block_i,
  input  logic [63:0] new_flat_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic        dropped_o,
  output logic [6:0]  entry_count_o
);

  localparam int KEY_W = 8 * KEY_BYTES;
  localparam int CW    = $clog2(DEPTH + 1);

  kqt_pkg::state_e  state_q, state_d;
  kqt_pkg::seq_ctrl_t ctl;

  logic [2:0]       op_q;
  logic [7:0]       grp_q, ngrp_q;
  logic [KEY_W-1:0] key_q, nkey_q;
  logic [31:0]      amt_q;
  logic [5:0]       pos_q;

  logic [CW-1:0]    occ_q, occ_d;
  logic [DEPTH-1:0] match_vec, match_q, incl;

  logic             out_valid_q, out_valid_d;
  logic             found_q, found_d, dropped_q, dropped_d;
  logic [CW-1:0]    count_q;

  logic             full, pos_ok, any_match;
  logic             is_app, is_rmk, is_rmp, is_qry, is_ren;

  kqt_pkg::cell_ctrl_t ctrl [DEPTH];
  logic [7:0]       c_grp [DEPTH];
  logic [KEY_W-1:0] c_key [DEPTH];
  logic [31:0]      c_amt [DEPTH];
  logic [7:0]       wr_grp;
  logic [KEY_W-1:0] wr_key;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      kqt_pkg::ST_IDLE:  if (in_valid_i) state_d = kqt_pkg::ST_MATCH;
      kqt_pkg::ST_MATCH: state_d = kqt_pkg::ST_APPLY;
      kqt_pkg::ST_APPLY: if (!out_valid_q || !out_stall_i) state_d = kqt_pkg::ST_IDLE;
      default:           state_d = kqt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_q)
      kqt_pkg::ST_IDLE: begin
        ctl.capture = in_valid_i;
      end
      kqt_pkg::ST_MATCH: begin
        ctl.in_stall = 1'b1;
        ctl.match_en = 1'b1;
      end
      kqt_pkg::ST_APPLY: begin
        ctl.in_stall = 1'b1;
        ctl.apply    = !out_valid_q || !out_stall_i;
      end
      default: begin
        ctl.in_stall = 1'b1;
      end
    endcase
  end

  assign in_stall_o = ctl.in_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kqt_pkg::ST_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.capture) begin
      op_q   <= op_i;
      grp_q  <= entry_block_i;
      key_q  <= flat_id_i[KEY_W-1:0];
      amt_q  <= amount_cents_i;
      pos_q  <= position_i;
      ngrp_q <= new_block_i;
      nkey_q <= new_flat_id_i[KEY_W-1:0];
    end
    if (ctl.match_en) begin
      match_q <= match_vec;
    end
    if (ctl.apply) begin
      found_q   <= found_d;
      dropped_q <= dropped_d;
      count_q   <= occ_d;
    end
  end

  // Operation decode.
  always_comb begin
    is_app = 1'b0;
    is_rmk = 1'b0;
    is_rmp = 1'b0;
    is_qry = 1'b0;
    is_ren = 1'b0;
    case (kqt_pkg::op_e'(op_q))
      kqt_pkg::OP_APPEND:     is_app = 1'b1;
      kqt_pkg::OP_REMOVE_KEY: is_rmk = 1'b1;
      kqt_pkg::OP_REMOVE_POS: is_rmp = 1'b1;
      kqt_pkg::OP_QUERY:      is_qry = 1'b1;
      kqt_pkg::OP_RENAME:     is_ren = 1'b1;
      default:                ;
    endcase
  end

  assign full      = (occ_q == CW'(DEPTH));
  assign pos_ok    = 32'(pos_q) < 32'(occ_q);
  assign any_match = |match_q;

  always_comb begin
    found_d   = 1'b0;
    dropped_d = 1'b0;
    occ_d     = occ_q;
    if (is_app) begin
      dropped_d = full;
    end else if (is_rmk || is_qry || is_ren) begin
      found_d = any_match;
    end else if (is_rmp) begin
      found_d = pos_ok;
    end
    if (ctl.apply) begin
      if (is_app && !full) begin
        occ_d = occ_q + CW'(1);
      end else if ((is_rmk && any_match) || (is_rmp && pos_ok)) begin
        occ_d = occ_q - CW'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl.apply) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign dropped_o     = dropped_q;
  assign entry_count_o = 7'(count_q);

  // Cell chain.
  kqt_first #(.DEPTH(DEPTH)) u_first (
    .match_i (match_q),
    .incl_o  (incl)
  );

  assign wr_grp = is_ren ? ngrp_q : grp_q;
  assign wr_key = is_ren ? nkey_q : key_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [7:0]       nb_grp;
    logic [KEY_W-1:0] nb_key;
    logic [31:0]      nb_amt;
    logic             cell_match;

    if (i < DEPTH - 1) begin : g_nb
      assign nb_grp = c_grp[i+1];
      assign nb_key = c_key[i+1];
      assign nb_amt = c_amt[i+1];
    end else begin : g_last
      assign nb_grp = c_grp[i];
      assign nb_key = c_key[i];
      assign nb_amt = c_amt[i];
    end

    assign ctrl[i].shift  = ctl.apply &&
                            ((is_rmk && incl[i]) ||
                             (is_rmp && pos_ok && (i >= 32'(pos_q))));
    assign ctrl[i].load   = ctl.apply && is_app && !full && (i == 32'(occ_q));
    assign ctrl[i].rename = ctl.apply && is_ren && match_q[i];

    kqt_cell #(.KEY_W(KEY_W)) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl[i]),
      .nb_grp_i  (nb_grp),
      .nb_key_i  (nb_key),
      .nb_amt_i  (nb_amt),
      .wr_grp_i  (wr_grp),
      .wr_key_i  (wr_key),
      .wr_amt_i  (amt_q),
      .cmp_grp_i (grp_q),
      .cmp_key_i (key_q),
      .grp_o     (c_grp[i]),
      .key_o     (c_key[i]),
      .amt_o     (c_amt[i]),
      .match_o   (cell_match)
    );

    assign match_vec[i] = cell_match && (i < 32'(occ_q));
  end

endmodule

/* verif/tb_keyed_ordered_queue_table.sv */
// Self-checking testbench for the keyed ordered queue table with its own table predictor.
module tb_keyed_ordered_queue_table;

  localparam int DEPTH       = 64;
  localparam int KEY_BYTES   = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 10;

  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    bit       found;
    bit       dropped;
    bit [6:0] count;
  } table_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  op_i;
  logic [7:0]  entry_block_i;
  logic [63:0] flat_id_i;
  logic [31:0] amount_cents_i;
  logic [5:0]  position_i;
  logic [7:0]  new_block_i;
  logic [63:0] new_flat_id_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        found_o;
  logic        dropped_o;
  logic [6:0]  entry_count_o;

  logic [7:0]  tbl_group  [DEPTH];
  logic [63:0] tbl_key    [DEPTH];
  logic [31:0] tbl_amount [DEPTH];
  int          tbl_count;

  table_result_t pending_results[$];

  logic [7:0]  group_pool [4];
  logic [63:0] key_pool   [8];

  int error_count;
  int cycle_count;
  int hold_off_left;
  int stall_left;
  bit burst_mode;
  bit quiet_mode;

  keyed_ordered_queue_table #(
    .DEPTH     (DEPTH),
    .KEY_BYTES (KEY_BYTES)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .entry_block_i  (entry_block_i),
    .flat_id_i      (flat_id_i),
    .amount_cents_i (amount_cents_i),
    .position_i     (position_i),
    .new_block_i    (new_block_i),
    .new_flat_id_i  (new_flat_id_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .dropped_o      (dropped_o),
    .entry_count_o  (entry_count_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL keyed_ordered_queue_table");
      $finish;
    end
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_group();
    if ($urandom_range(0, 4) == 0) return 8'($urandom);
    return group_pool[$urandom_range(0, 3)];
  endfunction

  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
    return key_pool[$urandom_range(0, 7)];
  endfunction

  function automatic bit entry_matches(int idx, logic [7:0] grp, logic [63:0] key);
    return tbl_group[idx] == grp && tbl_key[idx] == key;
  endfunction

  function automatic void compact_from(int idx);
    for (int i = idx; i + 1 < tbl_count; i++) begin
      tbl_group[i]  = tbl_group[i + 1];
      tbl_key[i]    = tbl_key[i + 1];
      tbl_amount[i] = tbl_amount[i + 1];
    end
    tbl_count--;
  endfunction

  function automatic table_result_t apply_table_op(logic [2:0] op, logic [7:0] grp,
                                                   logic [63:0] key, logic [31:0] amt,
                                                   logic [5:0] pos, logic [7:0] ngrp,
                                                   logic [63:0] nkey);
    table_result_t res;
    int hit;
    res.found   = 1'b0;
    res.dropped = 1'b0;
    hit = -1;
    case (op)
      kqt_pkg::OP_APPEND: begin
        if (tbl_count >= DEPTH) begin
          res.dropped = 1'b1;
        end else begin
          tbl_group[tbl_count]  = grp;
          tbl_key[tbl_count]    = key;
          tbl_amount[tbl_count] = amt;
          tbl_count++;
        end
      end
      kqt_pkg::OP_REMOVE_KEY: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (hit < 0 && entry_matches(i, grp, key)) hit = i;
        end
        if (hit >= 0) begin
          compact_from(hit);
          res.found = 1'b1;
        end
      end
      kqt_pkg::OP_REMOVE_POS: begin
        if (int'(pos) < tbl_count) begin
          compact_from(int'(pos));
          res.found = 1'b1;
        end
      end
      kqt_pkg::OP_QUERY: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (entry_matches(i, grp, key)) res.found = 1'b1;
        end
      end
      kqt_pkg::OP_RENAME: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (entry_matches(i, grp, key)) begin
            tbl_group[i] = ngrp;
            tbl_key[i]   = nkey;
            res.found    = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    res.count = 7'(tbl_count);
    return res;
  endfunction

  task automatic send_beat(logic [2:0] op, logic [7:0] grp, logic [63:0] key,
                           logic [31:0] amt, logic [5:0] pos, logic [7:0] ngrp,
                           logic [63:0] nkey);
    int gap;
    gap = burst_mode ? 0 : rand_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    op_i           <= op;
    entry_block_i  <= grp;
    flat_id_i      <= key;
    amount_cents_i <= amt;
    position_i     <= pos;
    new_block_i    <= ngrp;
    new_flat_id_i  <= nkey;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(apply_table_op(op, grp, key, amt, pos, ngrp, nkey));
  endtask

  task automatic send_random_item(int append_pct);
    logic [2:0]  op;
    logic [7:0]  grp;
    logic [63:0] key;
    logic [5:0]  pos;
    int          r;
    int          idx;
    r = $urandom_range(0, 99);
    if (r < append_pct) begin
      op = kqt_pkg::OP_APPEND;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 28) op = kqt_pkg::OP_REMOVE_KEY;
      else if (r < 56) op = kqt_pkg::OP_REMOVE_POS;
      else if (r < 80) op = kqt_pkg::OP_QUERY;
      else if (r < 97) op = kqt_pkg::OP_RENAME;
      else op = OP_SPARE_5 + 3'($urandom_range(0, 2));
    end
    if (op != kqt_pkg::OP_APPEND && tbl_count > 0 && $urandom_range(0, 1) == 1) begin
      idx = $urandom_range(0, tbl_count - 1);
      grp = tbl_group[idx];
      key = tbl_key[idx];
    end else begin
      grp = pick_group();
      key = pick_key();
    end
    if (tbl_count > 0 && $urandom_range(0, 3) != 0) pos = 6'($urandom_range(0, tbl_count - 1));
    else pos = 6'($urandom_range(0, 63));
    send_beat(op, grp, key, $urandom, pos, pick_group(), pick_key());
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [63:0] k1;
    logic [63:0] k2;
    k1 = 64'h0000_0041_4243_4445;
    k2 = 64'h5a59_5857_5655_5453;
    send_beat(kqt_pkg::OP_QUERY, 8'h00, 64'd0, $urandom, 6'd0, 8'h00, 64'd0);
    send_beat(kqt_pkg::OP_REMOVE_KEY, 8'h00, 64'd0, $urandom, 6'd0, 8'h00, 64'd0);
    send_beat(kqt_pkg::OP_REMOVE_POS, 8'h00, 64'd0, $urandom, 6'd0, 8'h00, 64'd0);
    send_beat(kqt_pkg::OP_RENAME, 8'h00, 64'd0, $urandom, 6'd63, 8'hFF, '1);
    send_beat(kqt_pkg::OP_APPEND, 8'h00, 64'd0, 32'd0, 6'd0, 8'h00, 64'd0);
    send_beat(kqt_pkg::OP_APPEND, 8'hFF, '1, '1, 6'd63, 8'hFF, '1);
    send_beat(kqt_pkg::OP_APPEND, 8'h5A, k1, 32'd12345, 6'd21, 8'hA5, k2);
    send_beat(kqt_pkg::OP_APPEND, 8'h5A, k1, 32'd99, 6'd42, 8'h3C, k2);
    send_beat(kqt_pkg::OP_APPEND, 8'h00, 64'd0, 32'h8000_0000, 6'd0, 8'h00, 64'd0);
    send_beat(kqt_pkg::OP_QUERY, 8'hFF, '1, $urandom, 6'd0, 8'h00, 64'd0);
    send_beat(kqt_pkg::OP_QUERY, 8'hFE, '1, $urandom, 6'd0, 8'h00, 64'd0);
    send_beat(kqt_pkg::OP_QUERY, 8'hFF, 64'h7FFF_FFFF_FFFF_FFFF, $urandom, 6'd0, 8'h00,
              64'd0);
    send_beat(kqt_pkg::OP_REMOVE_KEY, 8'h00, 64'd0, $urandom, 6'd0, 8'h00, 64'd0);
    send_beat(kqt_pkg::OP_RENAME, 8'h5A, k1, $urandom, 6'd0, 8'h33, k2);
    send_beat(kqt_pkg::OP_QUERY, 8'h5A, k1, $urandom, 6'd0, 8'h00, 64'd0);
    send_beat(kqt_pkg::OP_QUERY, 8'h33, k2, $urandom, 6'd0, 8'h00, 64'd0);
    send_beat(kqt_pkg::OP_REMOVE_POS, 8'h00, 64'd0, $urandom, 6'd63, 8'h00, 64'd0);
    send_beat(kqt_pkg::OP_REMOVE_POS, 8'h00, 64'd0, $urandom, 6'd4, 8'h00, 64'd0);
    send_beat(kqt_pkg::OP_REMOVE_POS, 8'h00, 64'd0, $urandom, 6'd3, 8'h00, 64'd0);
    send_beat(kqt_pkg::OP_REMOVE_POS, 8'h00, 64'd0, $urandom, 6'd0, 8'h00, 64'd0);
    send_beat(OP_SPARE_5, 8'h33, k2, '1, 6'd0, 8'h00, 64'd0);
    send_beat(OP_SPARE_6, 8'hFF, '1, '1, 6'd63, 8'hFF, '1);
    send_beat(OP_SPARE_7, 8'h33, k2, 32'd0, 6'd0, 8'h00, 64'd0);
    send_beat(kqt_pkg::OP_RENAME, 8'h77, k1, $urandom, 6'd0, 8'h11, k1);
    send_beat(kqt_pkg::OP_REMOVE_KEY, 8'h33, k2, $urandom, 6'd0, 8'h00, 64'd0);
  endtask

  task automatic test_full_table();
    while (tbl_count < DEPTH) send_random_item(100);
    repeat (3) send_random_item(100);
    send_beat(kqt_pkg::OP_REMOVE_POS, pick_group(), pick_key(), $urandom, 6'd63,
              pick_group(), pick_key());
    send_random_item(100);
    send_beat(kqt_pkg::OP_REMOVE_POS, pick_group(), pick_key(), $urandom, 6'd0,
              pick_group(), pick_key());
    send_random_item(100);
    send_random_item(100);
    repeat (10) send_random_item(0);
  endtask

  task automatic test_backpressure();
    hold_off_left = 200;
    burst_mode = 1'b1;
    repeat (20) send_random_item(50);
    burst_mode = 1'b0;
    wait_results_drained();
    repeat (20) send_random_item(50);
    wait_results_drained();
  endtask

  task automatic test_no_idle();
    burst_mode = 1'b1;
    quiet_mode = 1'b1;
    repeat (200) send_random_item(45);
    burst_mode = 1'b0;
    quiet_mode = 1'b0;
  endtask

  task automatic test_random();
    for (int n = 0; n < 1500; n++) begin
      send_random_item(((n / 150) % 2 == 0) ? 60 : 15);
    end
  endtask

  initial begin
    out_stall_i = 1'b0;
    stall_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        out_stall_i <= 1'b1;
        hold_off_left--;
      end else if (quiet_mode) begin
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = rand_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    table_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        if (error_count < MAX_REPORTS) begin
          $display("result beat with nothing expected: found=%b dropped=%b count=%0d",
                   found_o, dropped_o, entry_count_o);
        end
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (found_o !== exp_res.found || dropped_o !== exp_res.dropped ||
            entry_count_o !== exp_res.count) begin
          if (error_count < MAX_REPORTS) begin
            $display("mismatch: expected found=%b dropped=%b count=%0d, got %b %b %0d",
                     exp_res.found, exp_res.dropped, exp_res.count,
                     found_o, dropped_o, entry_count_o);
          end
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    op_i           = kqt_pkg::OP_APPEND;
    entry_block_i  = '0;
    flat_id_i      = '0;
    amount_cents_i = '0;
    position_i     = '0;
    new_block_i    = '0;
    new_flat_id_i  = '0;
    error_count    = 0;
    cycle_count    = 0;
    hold_off_left  = 0;
    burst_mode     = 1'b0;
    quiet_mode     = 1'b0;
    tbl_count      = 0;
    group_pool[0] = 8'h00;
    group_pool[1] = 8'hFF;
    group_pool[2] = 8'($urandom);
    group_pool[3] = 8'($urandom);
    key_pool[0] = 64'd0;
    key_pool[1] = '1;
    for (int i = 2; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_full_table();
    test_backpressure();
    test_no_idle();
    test_random();

    wait_results_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASS keyed_ordered_queue_table");
    end else begin
      $display("FAIL keyed_ordered_queue_table");
    end
    $finish;
  end

endmodule
